### rtl/compound_box_sweep_collision_macros.svh
`ifndef COMPOUND_BOX_SWEEP_COLLISION_MACROS_SVH
`define COMPOUND_BOX_SWEEP_COLLISION_MACROS_SVH
// assertion helpers
`define CBSC_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("lbl failed");
`define CBSC_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("lbl failed");
`endif

### rtl/cbsc_pkg.sv
package cbsc_pkg;
   localparam int MAX_SUBBOXES_DEF = 16;
   localparam logic [15:0] TIME_STEP_RESET = 16'd1092;
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD_MOVER = 2'd1;
   localparam logic [1:0] OP_ADD_OBST = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;
   localparam logic signed [33:0] Q_MIN = -34'sd2147483648;
   localparam logic signed [33:0] Q_MAX = 34'sd2147483647;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [33:0] r;
      begin
         r = v;
         if (v < Q_MIN) r = Q_MIN;
         else if (v > Q_MAX) r = Q_MAX;
         return r[31:0];
      end
   endfunction

   function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      return sat32(34'(a) + 34'(b));
   endfunction

   typedef struct packed {
      logic load_query;
      logic delta_go;
      logic delta_sel;
      logic trial_set;
      logic pair_clr;
      logic pair_go;
   } ctl_type;

   typedef struct packed {
      logic bound_ok;
      logic pair_hit;
      logic pair_last;
      logic vel_x_nz;
      logic vel_y_nz;
   } sts_type;
endpackage

### rtl/cbsc_ram.sv
module cbsc_ram #(parameter int WIDTH = 8, parameter int DEPTH = 16) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule

### rtl/cbsc_datapath.sv
module cbsc_datapath import cbsc_pkg::*; #(parameter int MAX_SUBBOXES = MAX_SUBBOXES_DEF) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [1:0] op,
   input  logic signed [31:0] box_x, box_y,
   input  logic [23:0] box_w, box_h,
   input  logic signed [31:0] old_x, old_y, vel_x, vel_y, obs_x, obs_y,
   input  logic [1:0] enable_flags,
   input  logic [15:0] time_step,
   input  ctl_type ctl,
   output sts_type sts,
   output logic overflow
);
   localparam int AW = $clog2(MAX_SUBBOXES > 1 ? MAX_SUBBOXES : 2);
   localparam int CW = $clog2(MAX_SUBBOXES + 1);

   logic [CW-1:0] mcnt_ff, mcnt_in, ocnt_ff, ocnt_in;
   logic ovf_ff, ovf_in;
   logic signed [31:0] mext_ff [4], oext_ff [4];
   logic signed [31:0] mext_in [4], oext_in [4];
   logic signed [31:0] mx_in, my_in;
   logic is_m, is_o, full;
   logic [AW-1:0] wa;

   assign is_m = accept && op == OP_ADD_MOVER;
   assign is_o = accept && op == OP_ADD_OBST;
   assign mx_in = sadd(box_x, 32'(box_w));
   assign my_in = sadd(box_y, 32'(box_h));
   assign full = is_m ? (mcnt_ff >= CW'(MAX_SUBBOXES)) : (ocnt_ff >= CW'(MAX_SUBBOXES));
   assign wa = is_m ? mcnt_ff[AW-1:0] : ocnt_ff[AW-1:0];

   always_comb begin
      mcnt_in = mcnt_ff; ocnt_in = ocnt_ff; ovf_in = ovf_ff;
      mext_in = mext_ff; oext_in = oext_ff;
      if (accept && op == OP_CLEAR) begin
         mcnt_in = '0; ocnt_in = '0; ovf_in = 1'b0;
         for (int k = 0; k < 4; k++) begin
            mext_in[k] = '0; oext_in[k] = '0;
         end
      end else if ((is_m || is_o) && full) begin
         ovf_in = 1'b1;
      end else if (is_m) begin
         mcnt_in = mcnt_ff + 1'b1;
         if (mcnt_ff == '0 || box_x < mext_ff[0]) mext_in[0] = box_x;
         if (mcnt_ff == '0 || box_y < mext_ff[1]) mext_in[1] = box_y;
         if (mcnt_ff == '0 || mx_in > mext_ff[2]) mext_in[2] = mx_in;
         if (mcnt_ff == '0 || my_in > mext_ff[3]) mext_in[3] = my_in;
      end else if (is_o) begin
         ocnt_in = ocnt_ff + 1'b1;
         if (ocnt_ff == '0 || box_x < oext_ff[0]) oext_in[0] = box_x;
         if (ocnt_ff == '0 || box_y < oext_ff[1]) oext_in[1] = box_y;
         if (ocnt_ff == '0 || mx_in > oext_ff[2]) oext_in[2] = mx_in;
         if (ocnt_ff == '0 || my_in > oext_ff[3]) oext_in[3] = my_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff <= '0; ocnt_ff <= '0; ovf_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            mext_ff[k] <= '0; oext_ff[k] <= '0;
         end
      end else begin
         mcnt_ff <= mcnt_in; ocnt_ff <= ocnt_in; ovf_ff <= ovf_in;
         mext_ff <= mext_in; oext_ff <= oext_in;
      end
   end
   assign overflow = ovf_ff;

   // query operands
   logic signed [31:0] qox_ff, qoy_ff, qvx_ff, qvy_ff, qbx_ff, qby_ff;
   logic [1:0] qen_ff;
   always_ff @(posedge clock) begin
      if (ctl.load_query) begin
         qox_ff <= old_x; qoy_ff <= old_y; qvx_ff <= vel_x; qvy_ff <= vel_y;
         qbx_ff <= obs_x; qby_ff <= obs_y; qen_ff <= enable_flags;
      end
   end
   assign sts.vel_x_nz = qvx_ff != '0;
   assign sts.vel_y_nz = qvy_ff != '0;

   // delta = round(vel*dt/2^16), registered product
   logic signed [48:0] prod_ff;
   logic signed [31:0] tx_ff, ty_ff;
   logic signed [48:0] rq;
   logic signed [33:0] dlt;
   always_ff @(posedge clock) begin
      if (ctl.delta_go)
         prod_ff <= (ctl.delta_sel ? 49'(qvy_ff) : 49'(qvx_ff)) * $signed({1'b0, time_step});
   end
   assign rq = prod_ff + 49'sd32768;
   assign dlt = 34'(rq >>> 16);
   always_ff @(posedge clock) begin
      if (ctl.trial_set) begin
         if (!ctl.delta_sel) begin
            tx_ff <= sat32(34'(qox_ff) + dlt); ty_ff <= qoy_ff;
         end else begin
            tx_ff <= qox_ff; ty_ff <= sat32(34'(qoy_ff) + dlt);
         end
      end
   end

   logic signed [31:0] ablx, ably, abhx, abhy, bblx, bbly, bbhx, bbhy;
   assign ablx = sadd(tx_ff, mext_ff[0]);
   assign ably = sadd(ty_ff, mext_ff[1]);
   assign abhx = sadd(tx_ff, mext_ff[2]);
   assign abhy = sadd(ty_ff, mext_ff[3]);
   assign bblx = sadd(qbx_ff, oext_ff[0]);
   assign bbly = sadd(qby_ff, oext_ff[1]);
   assign bbhx = sadd(qbx_ff, oext_ff[2]);
   assign bbhy = sadd(qby_ff, oext_ff[3]);
   assign sts.bound_ok = qen_ff == 2'b11 && mcnt_ff != '0 && ocnt_ff != '0 &&
                         ablx < bbhx && bblx < abhx && ably < bbhy && bbly < abhy;

   // pair walk: i over mover, j over obstacle
   logic [AW-1:0] i_ff, j_ff;
   logic [111:0] mrd, ord;
   cbsc_ram #(.WIDTH(112), .DEPTH(MAX_SUBBOXES)) u_mram (
      .clock(clock), .we(is_m && !full), .waddr(wa),
      .wdata({box_x, box_y, box_w, box_h}), .raddr(i_ff), .rdata(mrd));
   cbsc_ram #(.WIDTH(112), .DEPTH(MAX_SUBBOXES)) u_oram (
      .clock(clock), .we(is_o && !full), .waddr(wa),
      .wdata({box_x, box_y, box_w, box_h}), .raddr(j_ff), .rdata(ord));

   logic j_last, last_ij;
   assign j_last = (CW+1)'(j_ff) == (CW+1)'(ocnt_ff) - (CW+1)'(1);
   assign last_ij = j_last && ((CW+1)'(i_ff) == (CW+1)'(mcnt_ff) - (CW+1)'(1));
   logic v1_ff, l1_ff, v2_ff, l2_ff;
   always_ff @(posedge clock) begin
      if (reset || ctl.pair_clr) begin
         i_ff <= '0; j_ff <= '0; v1_ff <= 1'b0; l1_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.pair_go; l1_ff <= ctl.pair_go && last_ij;
         if (ctl.pair_go) begin
            if (j_last) begin
               j_ff <= '0; i_ff <= i_ff + 1'b1;
            end else j_ff <= j_ff + 1'b1;
         end
      end
   end

   // stage 2: corners
   logic signed [31:0] alx_ff, aly_ff, blx_ff, bly_ff;
   logic [23:0] aw_ff, ah_ff, bw_ff, bh_ff;
   always_ff @(posedge clock) begin
      alx_ff <= sadd(tx_ff, mrd[111:80]); aly_ff <= sadd(ty_ff, mrd[79:48]);
      aw_ff <= mrd[47:24]; ah_ff <= mrd[23:0];
      blx_ff <= sadd(qbx_ff, ord[111:80]); bly_ff <= sadd(qby_ff, ord[79:48]);
      bw_ff <= ord[47:24]; bh_ff <= ord[23:0];
      if (reset || ctl.pair_clr) begin
         v2_ff <= 1'b0; l2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff; l2_ff <= l1_ff;
      end
   end
   logic signed [31:0] ahx, ahy, bhx, bhy;
   assign ahx = sadd(alx_ff, 32'(aw_ff));
   assign ahy = sadd(aly_ff, 32'(ah_ff));
   assign bhx = sadd(blx_ff, 32'(bw_ff));
   assign bhy = sadd(bly_ff, 32'(bh_ff));
   assign sts.pair_hit = v2_ff && alx_ff <= bhx && blx_ff <= ahx &&
                         aly_ff <= bhy && bly_ff <= ahy;
   assign sts.pair_last = l2_ff;
endmodule

### rtl/cbsc_ctrl.sv
module cbsc_ctrl import cbsc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [1:0] op,
   input  sts_type sts,
   output ctl_type ctl,
   output logic busy,
   output logic done,
   output logic hit_x,
   output logic hit_y
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL = 3'd1;
   localparam logic [2:0] S_TRIAL = 3'd2;
   localparam logic [2:0] S_BOUND = 3'd3;
   localparam logic [2:0] S_WALK = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_NEXT = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0] st_ff, st_in;
   logic axis_ff, axis_in, hx_ff, hx_in, hy_ff, hy_in;

   always_comb begin
      st_in = st_ff; axis_in = axis_ff; hx_in = hx_ff; hy_in = hy_ff;
      ctl = '0;
      ctl.delta_sel = axis_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (start && op == OP_QUERY) begin
               ctl.load_query = 1'b1; st_in = S_NEXT; axis_in = 1'b0;
               hx_in = 1'b0; hy_in = 1'b0;
            end
         end
         S_NEXT: begin
            if ((axis_ff ? sts.vel_y_nz : sts.vel_x_nz)) begin
               ctl.delta_go = 1'b1; st_in = S_MUL;
            end else if (axis_ff) st_in = S_DONE;
            else axis_in = 1'b1;
         end
         S_MUL: begin
            ctl.trial_set = 1'b1; st_in = S_TRIAL;
         end
         S_TRIAL: begin
            ctl.pair_clr = 1'b1; st_in = S_BOUND;
         end
         S_BOUND: begin
            if (sts.bound_ok) st_in = S_WALK;
            else if (axis_ff) st_in = S_DONE;
            else begin
               axis_in = 1'b1; st_in = S_NEXT;
            end
         end
         S_WALK: begin
            ctl.pair_go = 1'b1;
            st_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (sts.pair_hit || sts.pair_last) begin
               if (sts.pair_hit) begin
                  if (axis_ff) hy_in = 1'b1; else hx_in = 1'b1;
               end
               ctl.pair_clr = 1'b1;
               if (axis_ff) st_in = S_DONE;
               else begin
                  axis_in = 1'b1; st_in = S_NEXT;
               end
            end else begin
               // pairs issued past the last one are flushed by pair_clr
               ctl.pair_go = 1'b1;
            end
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; axis_ff <= 1'b0; hx_ff <= 1'b0; hy_ff <= 1'b0;
      end else begin
         st_ff <= st_in; axis_ff <= axis_in; hx_ff <= hx_in; hy_ff <= hy_in;
      end
   end
   assign busy = st_ff != S_IDLE;
   assign done = st_ff == S_DONE;
   assign hit_x = hx_ff;
   assign hit_y = hy_ff;
endmodule

### rtl/compound_box_sweep_collision.sv
// Compound box sweep collision test.
// Request channel: start/busy. A request is taken when start is high and busy
// low. Operations: clear, add mover subbox, add obstacle subbox, query.
// Clear and add give no response; busy stays low.
// A query raises busy and, when done, pulses rsp_valid for one cycle with
// rsp_hit_horizontal, rsp_hit_vertical and rsp_overflow.
// Query: the axes are handled in turn, horizontal first. An axis with zero
// velocity is skipped; a moving axis goes through the delta multiply, the
// trial position and the bounding test, then, if both enable flags are set,
// both lists are non-empty and the bounds overlap, the pair walk, which
// issues one subbox pair per cycle from the two subbox RAMs (one read port
// each) and ends at the first hit or when the last pair leaves the corner
// registers. After the last axis rsp_valid pulses; busy falls the cycle after.
// csr_we/csr_wdata write time_step (unsigned Q0.16) at any edge; write
// only while idle.
// Reset (synchronous, active high) empties both lists, clears overflow and
// sets time_step to 1092. The receiver cannot stall: the response is shown
// for exactly one cycle.
module compound_box_sweep_collision import cbsc_pkg::*; #(
   parameter int MAX_SUBBOXES = MAX_SUBBOXES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_operation,
   input  logic signed [31:0] req_box_x,
   input  logic signed [31:0] req_box_y,
   input  logic [23:0] req_box_w,
   input  logic [23:0] req_box_h,
   input  logic signed [31:0] req_old_x,
   input  logic signed [31:0] req_old_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_obstacle_x,
   input  logic signed [31:0] req_obstacle_y,
   input  logic [1:0] req_enable_flags,
   output logic rsp_valid,
   output logic rsp_hit_horizontal,
   output logic rsp_hit_vertical,
   output logic rsp_overflow,
   input  logic csr_we,
   input  logic [15:0] csr_wdata
);
   logic [15:0] ts_ff;
   always_ff @(posedge clock) begin
      if (reset) ts_ff <= TIME_STEP_RESET;
      else if (csr_we) ts_ff <= csr_wdata;
   end

   ctl_type ctl;
   sts_type sts;
   logic accept, ovf;
   assign accept = start && !busy;

   cbsc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(accept), .op(req_operation), .sts(sts),
      .ctl(ctl), .busy(busy), .done(rsp_valid), .hit_x(rsp_hit_horizontal),
      .hit_y(rsp_hit_vertical));

   cbsc_datapath #(.MAX_SUBBOXES(MAX_SUBBOXES)) u_dp (
      .clock(clock), .reset(reset), .accept(accept), .op(req_operation),
      .box_x(req_box_x), .box_y(req_box_y), .box_w(req_box_w), .box_h(req_box_h),
      .old_x(req_old_x), .old_y(req_old_y), .vel_x(req_vel_x), .vel_y(req_vel_y),
      .obs_x(req_obstacle_x), .obs_y(req_obstacle_y), .enable_flags(req_enable_flags),
      .time_step(ts_ff), .ctl(ctl), .sts(sts), .overflow(ovf));
   assign rsp_overflow = ovf;
endmodule

### rtl/cbsc_checker.sv
`include "compound_box_sweep_collision_macros.svh"
module cbsc_checker import cbsc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic [1:0] req_operation,
   input logic rsp_valid
);
   `CBSC_ASSERT_NXT(a_query_busy, clock, reset, start && !busy && req_operation == OP_QUERY, busy)
   `CBSC_ASSERT_NXT(a_add_idle, clock, reset, start && !busy && req_operation != OP_QUERY, !busy)
   `CBSC_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `CBSC_ASSERT_NXT(a_rsp_end, clock, reset, rsp_valid, !busy && !rsp_valid)
endmodule

bind compound_box_sweep_collision cbsc_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_operation(req_operation), .rsp_valid(rsp_valid));

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import cbsc_pkg::*;

   localparam int NSUB = MAX_SUBBOXES_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [1:0] op;
      logic signed [31:0] bx, by;
      logic [23:0] bw, bh;
      logic signed [31:0] old_x, old_y, vel_x, vel_y, obs_x, obs_y;
      logic [1:0] en;
   } request_type;

   typedef struct {
      logic hit_h, hit_v, ovf;
   } hit_result_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_operation = OP_CLEAR;
   logic signed [31:0] req_box_x = 0, req_box_y = 0;
   logic [23:0] req_box_w = 0, req_box_h = 0;
   logic signed [31:0] req_old_x = 0, req_old_y = 0, req_vel_x = 0, req_vel_y = 0;
   logic signed [31:0] req_obstacle_x = 0, req_obstacle_y = 0;
   logic [1:0] req_enable_flags = 0;
   logic rsp_valid, rsp_hit_horizontal, rsp_hit_vertical, rsp_overflow;
   logic csr_we = 0;
   logic [15:0] csr_wdata = 0;

   compound_box_sweep_collision u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_box_x(req_box_x), .req_box_y(req_box_y),
      .req_box_w(req_box_w), .req_box_h(req_box_h),
      .req_old_x(req_old_x), .req_old_y(req_old_y),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y),
      .req_obstacle_x(req_obstacle_x), .req_obstacle_y(req_obstacle_y),
      .req_enable_flags(req_enable_flags),
      .rsp_valid(rsp_valid), .rsp_hit_horizontal(rsp_hit_horizontal),
      .rsp_hit_vertical(rsp_hit_vertical), .rsp_overflow(rsp_overflow),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // list 0 is the mover, list 1 the obstacle
   longint sub_off[2][NSUB][2];
   longint sub_size[2][NSUB][2];
   longint bound[2][2][2];
   int sub_count[2];
   bit overflow_seen;
   longint frame_dt = longint'(TIME_STEP_RESET);

   hit_result_type hit_queue[$];
   bit failed = 0;
   int gap_pct = 0;
   int requests_sent = 0;
   int idle_cycles = 0;

   function automatic longint clamp32(longint v);
      if (v < -64'sd2147483648) return -64'sd2147483648;
      if (v > 64'sd2147483647) return 64'sd2147483647;
      return v;
   endfunction

   function automatic longint step_delta(longint vel);
      longint q;
      q = vel * frame_dt + 32768;
      return q >>> 16;
   endfunction

   function automatic bit trial_hits(longint mx, longint my, longint ox, longint oy,
                                     logic [1:0] en);
      longint alx, aly, ahx, ahy, blx, bly, bhx, bhy;
      if (en != 2'b11) return 0;
      if (sub_count[0] == 0 || sub_count[1] == 0) return 0;
      alx = clamp32(mx + bound[0][0][0]);
      aly = clamp32(my + bound[0][0][1]);
      ahx = clamp32(mx + bound[0][1][0]);
      ahy = clamp32(my + bound[0][1][1]);
      blx = clamp32(ox + bound[1][0][0]);
      bly = clamp32(oy + bound[1][0][1]);
      bhx = clamp32(ox + bound[1][1][0]);
      bhy = clamp32(oy + bound[1][1][1]);
      if (!(alx < bhx && blx < ahx && aly < bhy && bly < ahy)) return 0;
      for (int i = 0; i < sub_count[0]; i++) begin
         alx = clamp32(mx + sub_off[0][i][0]);
         aly = clamp32(my + sub_off[0][i][1]);
         ahx = clamp32(alx + sub_size[0][i][0]);
         ahy = clamp32(aly + sub_size[0][i][1]);
         for (int j = 0; j < sub_count[1]; j++) begin
            blx = clamp32(ox + sub_off[1][j][0]);
            bly = clamp32(oy + sub_off[1][j][1]);
            bhx = clamp32(blx + sub_size[1][j][0]);
            bhy = clamp32(bly + sub_size[1][j][1]);
            if (alx <= bhx && blx <= ahx && aly <= bhy && bly <= ahy) return 1;
         end
      end
      return 0;
   endfunction

   function automatic void predict_collision(request_type r);
      int l, n;
      longint x, y, mx, my;
      hit_result_type res;
      case (r.op)
         OP_CLEAR: begin
            sub_count = '{0, 0};
            bound = '{default: 0};
            overflow_seen = 0;
         end
         OP_ADD_MOVER, OP_ADD_OBST: begin
            l = (r.op == OP_ADD_MOVER) ? 0 : 1;
            n = sub_count[l];
            x = r.bx;
            y = r.by;
            mx = clamp32(x + longint'(r.bw));
            my = clamp32(y + longint'(r.bh));
            if (n >= NSUB) begin
               overflow_seen = 1;
            end else begin
               sub_off[l][n] = '{x, y};
               sub_size[l][n] = '{longint'(r.bw), longint'(r.bh)};
               if (n == 0 || x < bound[l][0][0]) bound[l][0][0] = x;
               if (n == 0 || y < bound[l][0][1]) bound[l][0][1] = y;
               if (n == 0 || mx > bound[l][1][0]) bound[l][1][0] = mx;
               if (n == 0 || my > bound[l][1][1]) bound[l][1][1] = my;
               sub_count[l] = n + 1;
            end
         end
         default: begin
            res.hit_h = 0;
            res.hit_v = 0;
            if (r.vel_x != 0)
               res.hit_h = trial_hits(clamp32(longint'(r.old_x) + step_delta(r.vel_x)),
                                      r.old_y, r.obs_x, r.obs_y, r.en);
            if (r.vel_y != 0)
               res.hit_v = trial_hits(r.old_x,
                                      clamp32(longint'(r.old_y) + step_delta(r.vel_y)),
                                      r.obs_x, r.obs_y, r.en);
            res.ovf = overflow_seen;
            hit_queue = {hit_queue, res};
         end
      endcase
   endfunction

   always @(posedge clock) begin
      hit_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (hit_queue.size() == 0) begin
            $error("response with no request pending");
            failed = 1;
         end else begin
            exp_r = hit_queue.pop_front();
            if (rsp_hit_horizontal !== exp_r.hit_h) begin
               $error("hit_horizontal exp %0d got %0b", exp_r.hit_h, rsp_hit_horizontal);
               failed = 1;
            end
            if (rsp_hit_vertical !== exp_r.hit_v) begin
               $error("hit_vertical exp %0d got %0b", exp_r.hit_v, rsp_hit_vertical);
               failed = 1;
            end
            if (rsp_overflow !== exp_r.ovf) begin
               $error("overflow exp %0d got %0b", exp_r.ovf, rsp_overflow);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send(request_type r);
      while ($urandom_range(99) < gap_pct) begin
         start <= 0;
         @(posedge clock);
      end
      req_operation <= r.op;
      req_box_x <= r.bx;
      req_box_y <= r.by;
      req_box_w <= r.bw;
      req_box_h <= r.bh;
      req_old_x <= r.old_x;
      req_old_y <= r.old_y;
      req_vel_x <= r.vel_x;
      req_vel_y <= r.vel_y;
      req_obstacle_x <= r.obs_x;
      req_obstacle_y <= r.obs_y;
      req_enable_flags <= r.en;
      start <= 1;
      do @(posedge clock); while (busy);
      predict_collision(r);
      requests_sent++;
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (hit_queue.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_time_step(logic [15:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      frame_dt = longint'(v);
      csr_we <= 0;
   endtask

   function automatic request_type make_req(logic [1:0] op);
      request_type r;
      r = '{op: op, en: 2'b11, default: 0};
      return r;
   endfunction

   function automatic int near(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic add_box(logic [1:0] op, int x, int y, int w, int h);
      request_type r;
      r = make_req(op);
      r.bx = x;
      r.by = y;
      r.bw = 24'(w);
      r.bh = 24'(h);
      send(r);
   endtask

   task automatic query(int ox0, int oy0, int vx, int vy, int bx, int by, logic [1:0] en);
      request_type r;
      r = make_req(OP_QUERY);
      r.old_x = ox0;
      r.old_y = oy0;
      r.vel_x = vx;
      r.vel_y = vy;
      r.obs_x = bx;
      r.obs_y = by;
      r.en = en;
      send(r);
   endtask

   task automatic test_empty_lists();
      query(0, 0, 256, 256, 0, 0, 2'b11);
      add_box(OP_ADD_MOVER, 0, 0, 256, 256);
      query(0, 0, 256, 256, 0, 0, 2'b11);
   endtask

   task automatic test_directed();
      send(make_req(OP_CLEAR));
      // corners touch only: bounding overlaps strictly, subboxes inclusive
      add_box(OP_ADD_MOVER, 0, 0, 256, 256);
      add_box(OP_ADD_MOVER, 512, 512, 256, 256);
      add_box(OP_ADD_OBST, 256, 256, 256, 256);
      for (int e = 0; e < 4; e++) query(0, 0, 1, 1, 0, 0, 2'(e));
      query(0, 0, 0, 0, 0, 0, 2'b11);
      query(0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 2'b11);
      query(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            32'sh80000000, 32'sh7fffffff, 2'b11);
      add_box(OP_ADD_OBST, 32'sh7fffff00, 32'sh80000000, 24'hffffff, 24'hffffff);
      query(32'sh7fffff00, 0, -1, 1, 0, 32'sh80000000, 2'b11);
      // fill the mover list past capacity
      for (int i = 0; i < NSUB; i++) add_box(OP_ADD_MOVER, -256 * i, 128 * i, 64, 64);
      query(0, 0, 256, -256, 0, 0, 2'b11);
      send(make_req(OP_CLEAR));
      query(0, 0, 256, -256, 0, 0, 2'b11);
   endtask

   task automatic random_scene();
      request_type r;
      int nm, nob, nq;
      bit wild;
      send(make_req(OP_CLEAR));
      nm = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
      nob = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4);
      for (int k = 0; k < nm + nob; k++) begin
         r = make_req(k < nm ? OP_ADD_MOVER : OP_ADD_OBST);
         wild = $urandom_range(15) == 0;
         r.bx = wild ? $urandom : near(2048);
         r.by = wild ? $urandom : near(2048);
         r.bw = 24'(wild ? $urandom : $urandom_range(1024));
         r.bh = 24'(wild ? $urandom : $urandom_range(1024));
         send(r);
      end
      nq = $urandom_range(1, 5);
      for (int k = 0; k < nq; k++) begin
         r = make_req(OP_QUERY);
         wild = $urandom_range(15) == 0;
         r.old_x = wild ? $urandom : near(2048);
         r.old_y = wild ? $urandom : near(2048);
         r.vel_x = wild ? $urandom : ($urandom_range(5) == 0 ? 0 : near(200000));
         r.vel_y = wild ? $urandom : ($urandom_range(5) == 0 ? 0 : near(200000));
         r.obs_x = wild ? $urandom : near(2048);
         r.obs_y = wild ? $urandom : near(2048);
         r.en = ($urandom_range(7) == 0) ? 2'($urandom) : 2'b11;
         send(r);
      end
      if ($urandom_range(7) == 0) begin
         r.op = 2'($urandom);
         r.bx = $urandom;
         r.by = $urandom;
         r.bw = 24'($urandom);
         r.bh = 24'($urandom);
         send(r);
      end
   endtask

   task automatic test_random(int pct, logic [15:0] dt, int quota);
      gap_pct = pct;
      set_time_step(dt);
      quota += requests_sent;
      while (requests_sent < quota) random_scene();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_empty_lists();
      test_directed();
      set_time_step(16'hffff);
      test_directed();
      set_time_step(16'h0000);
      test_directed();
      test_random(12, 16'($urandom), 350);
      test_random(68, TIME_STEP_RESET, 350);
      test_random(0, 16'($urandom_range(8192)), 350);
      drain();
      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/cbsc_pkg.sv
rtl/cbsc_ram.sv
rtl/cbsc_datapath.sv
rtl/cbsc_ctrl.sv
rtl/compound_box_sweep_collision.sv
rtl/cbsc_checker.sv
test/tb.sv
